/* sv/assert_macros.svh */
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// trigger at one edge implies the check at the next edge
`define ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

/* sv/nffla_pkg.sv */
// types, constants and microcode rom of the next-fit free-list allocator
`timescale 1ns / 1ps

package nffla_pkg;

    localparam int MemWords = 4096;
    localparam int AW       = $clog2(MemWords);
    localparam int DataW    = 16;
    localparam int SumW     = DataW + 1;
    localparam int CntW     = $clog2(MemWords + 2);
    localparam int UpcW     = 6;

    typedef struct packed {
        logic          kind;
        logic [11:0]   units;
        logic [11:0]   block_address;
    } t_in;

    typedef struct packed {
        logic [11:0]   granted_address;
        logic          ok;
    } t_out;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // memory operation
    localparam logic [1:0] M_NONE  = 2'd0;
    localparam logic [1:0] M_READ  = 2'd1;
    localparam logic [1:0] M_WRITE = 2'd2;

    // memory address select
    localparam logic [2:0] A_CNT   = 3'd0;
    localparam logic [2:0] A_PREV  = 3'd1;
    localparam logic [2:0] A_PREV1 = 3'd2;
    localparam logic [2:0] A_CUR   = 3'd3;
    localparam logic [2:0] A_CUR1  = 3'd4;
    localparam logic [2:0] A_BP    = 3'd5;
    localparam logic [2:0] A_BP1   = 3'd6;

    // write data select
    localparam logic [2:0] W_INIT  = 3'd0;
    localparam logic [2:0] W_T     = 3'd1;
    localparam logic [2:0] W_REST  = 3'd2;
    localparam logic [2:0] W_UNITS = 3'd3;
    localparam logic [2:0] W_CUR   = 3'd4;
    localparam logic [2:0] W_BP    = 3'd5;
    localparam logic [2:0] W_SUM   = 3'd6;

    // register transfer
    localparam logic [3:0] D_NONE      = 4'd0;
    localparam logic [3:0] D_LATCH     = 4'd1;
    localparam logic [3:0] D_CUR_RD    = 4'd2;
    localparam logic [3:0] D_SZ_RD     = 4'd3;
    localparam logic [3:0] D_T_RD      = 4'd4;
    localparam logic [3:0] D_CUR_SPLIT = 4'd5;
    localparam logic [3:0] D_PREV_STEP = 4'd6;
    localparam logic [3:0] D_ROVER     = 4'd7;
    localparam logic [3:0] D_CNT_INC   = 4'd8;

    // jump condition
    localparam logic [3:0] C_NEVER       = 4'd0;
    localparam logic [3:0] C_ALWAYS      = 4'd1;
    localparam logic [3:0] C_KIND_FREE   = 4'd2;
    localparam logic [3:0] C_SZ_LT_UNITS = 4'd3;
    localparam logic [3:0] C_SPLIT       = 4'd4;
    localparam logic [3:0] C_T_SELF      = 4'd5;
    localparam logic [3:0] C_CUR_ROVER   = 4'd6;
    localparam logic [3:0] C_ALLOC_MORE  = 4'd7;
    localparam logic [3:0] C_BREAK       = 4'd8;
    localparam logic [3:0] C_FREE_MORE   = 4'd9;
    localparam logic [3:0] C_BP_ADJ_NX   = 4'd10;
    localparam logic [3:0] C_P_ADJ_BP    = 4'd11;
    localparam logic [3:0] C_CLR_MORE    = 4'd12;

    // result select
    localparam logic [1:0] R_FAIL  = 2'd0;
    localparam logic [1:0] R_GRANT = 2'd1;
    localparam logic [1:0] R_FREE  = 2'd2;

    typedef struct packed {
        logic [1:0]      mem;
        logic [2:0]      asel;
        logic [2:0]      wsel;
        logic [3:0]      dop;
        logic [3:0]      cond;
        logic            done;
        logic [1:0]      res;
        logic [UpcW-1:0] target;
    } t_uword;

    // step addresses
    localparam logic [UpcW-1:0] U_CLR   = UpcW'(0);
    localparam logic [UpcW-1:0] U_IDLE  = UpcW'(1);
    localparam logic [UpcW-1:0] U_A0    = UpcW'(2);
    localparam logic [UpcW-1:0] U_A1    = UpcW'(3);
    localparam logic [UpcW-1:0] U_A2    = UpcW'(4);
    localparam logic [UpcW-1:0] U_A3    = UpcW'(5);
    localparam logic [UpcW-1:0] U_A4    = UpcW'(6);
    localparam logic [UpcW-1:0] U_A5    = UpcW'(7);
    localparam logic [UpcW-1:0] U_A6    = UpcW'(8);
    localparam logic [UpcW-1:0] U_A7    = UpcW'(9);
    localparam logic [UpcW-1:0] U_A8    = UpcW'(10);
    localparam logic [UpcW-1:0] U_A9    = UpcW'(11);
    localparam logic [UpcW-1:0] U_S0    = UpcW'(12);
    localparam logic [UpcW-1:0] U_S1    = UpcW'(13);
    localparam logic [UpcW-1:0] U_GRANT = UpcW'(14);
    localparam logic [UpcW-1:0] U_M0    = UpcW'(15);
    localparam logic [UpcW-1:0] U_M1    = UpcW'(16);
    localparam logic [UpcW-1:0] U_M2    = UpcW'(17);
    localparam logic [UpcW-1:0] U_FAIL  = UpcW'(18);
    localparam logic [UpcW-1:0] U_F0    = UpcW'(19);
    localparam logic [UpcW-1:0] U_F1    = UpcW'(20);
    localparam logic [UpcW-1:0] U_F2    = UpcW'(21);
    localparam logic [UpcW-1:0] U_F3    = UpcW'(22);
    localparam logic [UpcW-1:0] U_F4    = UpcW'(23);
    localparam logic [UpcW-1:0] U_G0    = UpcW'(24);
    localparam logic [UpcW-1:0] U_G1    = UpcW'(25);
    localparam logic [UpcW-1:0] U_G2    = UpcW'(26);
    localparam logic [UpcW-1:0] U_G3    = UpcW'(27);
    localparam logic [UpcW-1:0] U_N0    = UpcW'(28);
    localparam logic [UpcW-1:0] U_N1    = UpcW'(29);
    localparam logic [UpcW-1:0] U_N2    = UpcW'(30);
    localparam logic [UpcW-1:0] U_N3    = UpcW'(31);
    localparam logic [UpcW-1:0] U_N4    = UpcW'(32);
    localparam logic [UpcW-1:0] U_N5    = UpcW'(33);
    localparam logic [UpcW-1:0] U_H0    = UpcW'(34);
    localparam logic [UpcW-1:0] U_H1    = UpcW'(35);
    localparam logic [UpcW-1:0] U_H2    = UpcW'(36);
    localparam logic [UpcW-1:0] U_H3    = UpcW'(37);
    localparam logic [UpcW-1:0] U_K0    = UpcW'(38);
    localparam logic [UpcW-1:0] U_K1    = UpcW'(39);
    localparam logic [UpcW-1:0] U_K2    = UpcW'(40);
    localparam logic [UpcW-1:0] U_K3    = UpcW'(41);
    localparam logic [UpcW-1:0] U_K4    = UpcW'(42);
    localparam logic [UpcW-1:0] U_K5    = UpcW'(43);
    localparam logic [UpcW-1:0] U_FDONE = UpcW'(44);

    function automatic t_uword uw(
        input logic [1:0]      mem,
        input logic [2:0]      asel,
        input logic [2:0]      wsel,
        input logic [3:0]      dop,
        input logic [3:0]      cond,
        input logic            done,
        input logic [1:0]      res,
        input logic [UpcW-1:0] target
    );
        t_uword w;
        w.mem    = mem;
        w.asel   = asel;
        w.wsel   = wsel;
        w.dop    = dop;
        w.cond   = cond;
        w.done   = done;
        w.res    = res;
        w.target = target;
        return w;
    endfunction

    // control store: one word per step
    function automatic t_uword ucode(input logic [UpcW-1:0] upc);
        t_uword w;
        unique case (upc)
            // power-up sweep over the heap
            U_CLR:   w = uw(M_WRITE, A_CNT,   W_INIT,  D_CNT_INC,   C_CLR_MORE,    1'b0, R_FAIL,  U_CLR);
            U_IDLE:  w = uw(M_NONE,  A_PREV,  W_T,     D_LATCH,     C_KIND_FREE,   1'b0, R_FAIL,  U_F0);
            // allocate: walk from the rover
            U_A0:    w = uw(M_READ,  A_PREV,  W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_A1:    w = uw(M_NONE,  A_PREV,  W_T,     D_CUR_RD,    C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_A2:    w = uw(M_READ,  A_CUR1,  W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_A3:    w = uw(M_NONE,  A_PREV,  W_T,     D_SZ_RD,     C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_A4:    w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_SZ_LT_UNITS, 1'b0, R_FAIL,  U_M0);
            U_A5:    w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_SPLIT,       1'b0, R_FAIL,  U_S0);
            U_A6:    w = uw(M_READ,  A_CUR,   W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_A7:    w = uw(M_NONE,  A_PREV,  W_T,     D_T_RD,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_A8:    w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_T_SELF,      1'b0, R_FAIL,  U_FAIL);
            U_A9:    w = uw(M_WRITE, A_PREV,  W_T,     D_NONE,      C_ALWAYS,      1'b0, R_FAIL,  U_GRANT);
            U_S0:    w = uw(M_WRITE, A_CUR1,  W_REST,  D_CUR_SPLIT, C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_S1:    w = uw(M_WRITE, A_CUR1,  W_UNITS, D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_GRANT: w = uw(M_NONE,  A_PREV,  W_T,     D_ROVER,     C_ALWAYS,      1'b1, R_GRANT, U_IDLE);
            U_M0:    w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_CUR_ROVER,   1'b0, R_FAIL,  U_FAIL);
            U_M1:    w = uw(M_READ,  A_CUR,   W_T,     D_PREV_STEP, C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_M2:    w = uw(M_NONE,  A_PREV,  W_T,     D_CUR_RD,    C_ALLOC_MORE,  1'b0, R_FAIL,  U_A2);
            U_FAIL:  w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_ALWAYS,      1'b1, R_FAIL,  U_IDLE);
            // free: find the insertion point
            U_F0:    w = uw(M_READ,  A_PREV,  W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_F1:    w = uw(M_NONE,  A_PREV,  W_T,     D_CUR_RD,    C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_F2:    w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_BREAK,       1'b0, R_FAIL,  U_G0);
            U_F3:    w = uw(M_READ,  A_CUR,   W_T,     D_PREV_STEP, C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_F4:    w = uw(M_NONE,  A_PREV,  W_T,     D_CUR_RD,    C_FREE_MORE,   1'b0, R_FAIL,  U_F2);
            // join with the upper neighbor
            U_G0:    w = uw(M_READ,  A_BP1,   W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_G1:    w = uw(M_NONE,  A_PREV,  W_T,     D_SZ_RD,     C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_G2:    w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_BP_ADJ_NX,   1'b0, R_FAIL,  U_N0);
            U_G3:    w = uw(M_WRITE, A_BP,    W_CUR,   D_NONE,      C_ALWAYS,      1'b0, R_FAIL,  U_H0);
            U_N0:    w = uw(M_READ,  A_CUR1,  W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_N1:    w = uw(M_NONE,  A_PREV,  W_T,     D_T_RD,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_N2:    w = uw(M_WRITE, A_BP1,   W_SUM,   D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_N3:    w = uw(M_READ,  A_CUR,   W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_N4:    w = uw(M_NONE,  A_PREV,  W_T,     D_T_RD,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_N5:    w = uw(M_WRITE, A_BP,    W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            // join with the lower neighbor
            U_H0:    w = uw(M_READ,  A_PREV1, W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_H1:    w = uw(M_NONE,  A_PREV,  W_T,     D_SZ_RD,     C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_H2:    w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_P_ADJ_BP,    1'b0, R_FAIL,  U_K0);
            U_H3:    w = uw(M_WRITE, A_PREV,  W_BP,    D_NONE,      C_ALWAYS,      1'b0, R_FAIL,  U_FDONE);
            U_K0:    w = uw(M_READ,  A_BP1,   W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_K1:    w = uw(M_NONE,  A_PREV,  W_T,     D_T_RD,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_K2:    w = uw(M_WRITE, A_PREV1, W_SUM,   D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_K3:    w = uw(M_READ,  A_BP,    W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_K4:    w = uw(M_NONE,  A_PREV,  W_T,     D_T_RD,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_K5:    w = uw(M_WRITE, A_PREV,  W_T,     D_NONE,      C_NEVER,       1'b0, R_FAIL,  U_IDLE);
            U_FDONE: w = uw(M_NONE,  A_PREV,  W_T,     D_ROVER,     C_ALWAYS,      1'b1, R_FREE,  U_IDLE);
            default: w = uw(M_NONE,  A_PREV,  W_T,     D_NONE,      C_ALWAYS,      1'b0, R_FAIL,  U_IDLE);
        endcase
        return w;
    endfunction

endpackage

/* sv/next_fit_free_list_allocator.sv */
// next-fit free-list allocator: microcoded sequencer over a single-port heap memory
// after reset a sweep writes every heap word, with o_in_stall high
// one item at a time; every heap read takes a read step and a use step on the one port
// allocate: walks the free blocks from the rover until one fits
// free: walks the free blocks passed on the way to the insertion point, then joins neighbors
// the result sits in the output register from the cycle after the last step
`timescale 1ns / 1ps
`include "assert_macros.svh"

module next_fit_free_list_allocator
    import nffla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic [DataW-1:0] mem [MemWords];

    logic [UpcW-1:0]  r_upc,   n_upc;
    logic [CntW-1:0]  r_cnt,   n_cnt;
    logic [AW-1:0]    r_rover, n_rover;
    logic [AW-1:0]    r_prev,  n_prev;
    logic [AW-1:0]    r_cur,   n_cur;
    logic [AW-1:0]    r_bp,    n_bp;
    logic [11:0]      r_units, n_units;
    logic [DataW-1:0] r_sz,    n_sz;
    logic [DataW-1:0] r_t,     n_t;
    logic             r_out_valid, n_out_valid;
    t_out             r_out,   n_out;
    logic [DataW-1:0] r_rdata;

    t_uword           cw;
    logic             out_busy;
    logic             hold;
    logic             fire;
    logic             cond_true;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [DataW-1:0] mem_wdata;
    logic [DataW-1:0] sz_minus;
    logic [DataW-1:0] rest;
    logic [DataW-1:0] sum_w;
    logic             bp_gt_p;
    logic             bp_lt_nx;
    logic             brk;
    t_out             result;

    assign cw       = ucode(r_upc);
    assign out_busy = r_out_valid && i_out_stall;
    // idle waits for an item, a finishing step waits for room in the output register
    assign hold     = (r_upc == U_IDLE && !i_in_valid) || (cw.done && out_busy);
    assign fire     = !hold;

    assign o_in_stall  = (r_upc != U_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign sz_minus = r_sz - DataW'(r_units);
    assign rest     = sz_minus - DataW'(2);
    assign sum_w    = r_sz + DataW'(2) + r_t;
    assign bp_gt_p  = r_bp > r_prev;
    assign bp_lt_nx = r_bp < r_cur;
    // insertion point: between p and its successor, or at the wrap of the list
    assign brk      = (bp_gt_p && bp_lt_nx) || (r_prev >= r_cur && (bp_gt_p || bp_lt_nx));

    always_comb begin
        unique case (cw.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_KIND_FREE:   cond_true = (i_in.kind == KIND_FREE);
            C_SZ_LT_UNITS: cond_true = r_sz < DataW'(r_units);
            C_SPLIT:       cond_true = sz_minus >= DataW'(2);
            C_T_SELF:      cond_true = (r_t[AW-1:0] == r_cur);
            C_CUR_ROVER:   cond_true = (r_cur == r_rover);
            C_ALLOC_MORE:  cond_true = (r_cnt <= CntW'(MemWords));
            C_BREAK:       cond_true = brk;
            C_FREE_MORE:   cond_true = (r_cnt < CntW'(MemWords));
            C_BP_ADJ_NX:   cond_true = (SumW'(r_bp) + SumW'(2) + SumW'(r_sz)) == SumW'(r_cur);
            C_P_ADJ_BP:    cond_true = (SumW'(r_prev) + SumW'(2) + SumW'(r_sz)) == SumW'(r_bp);
            C_CLR_MORE:    cond_true = (r_cnt != CntW'(MemWords - 1));
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cw.asel)
            A_CNT:   mem_addr = r_cnt[AW-1:0];
            A_PREV:  mem_addr = r_prev;
            A_PREV1: mem_addr = r_prev + AW'(1);
            A_CUR:   mem_addr = r_cur;
            A_CUR1:  mem_addr = r_cur + AW'(1);
            A_BP:    mem_addr = r_bp;
            A_BP1:   mem_addr = r_bp + AW'(1);
            default: mem_addr = r_prev;
        endcase
    end

    always_comb begin
        unique case (cw.wsel)
            // one free block spanning the heap, all other words zero
            W_INIT:  mem_wdata = (r_cnt == CntW'(1)) ? DataW'(MemWords - 2) : '0;
            W_T:     mem_wdata = r_t;
            W_REST:  mem_wdata = rest;
            W_UNITS: mem_wdata = DataW'(r_units);
            W_CUR:   mem_wdata = DataW'(r_cur);
            W_BP:    mem_wdata = DataW'(r_bp);
            W_SUM:   mem_wdata = sum_w;
            default: mem_wdata = r_t;
        endcase
    end

    assign mem_we = fire && (cw.mem == M_WRITE);
    assign mem_re = fire && (cw.mem == M_READ);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_comb begin
        unique case (cw.res)
            R_GRANT: begin
                result.granted_address = 12'(r_cur + AW'(2));
                result.ok              = 1'b1;
            end
            R_FREE: begin
                result.granted_address = '0;
                result.ok              = 1'b1;
            end
            default: begin
                result.granted_address = '0;
                result.ok              = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_upc       = r_upc;
        n_cnt       = r_cnt;
        n_rover     = r_rover;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_bp        = r_bp;
        n_units     = r_units;
        n_sz        = r_sz;
        n_t         = r_t;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (fire) begin
            n_upc = cond_true ? cw.target : r_upc + UpcW'(1);
            unique case (cw.dop)
                D_NONE: begin
                end
                D_LATCH: begin
                    n_units = i_in.units;
                    n_bp    = AW'(i_in.block_address) - AW'(2);
                    n_prev  = r_rover;
                    n_cnt   = '0;
                end
                D_CUR_RD: begin
                    n_cur = r_rdata[AW-1:0];
                end
                D_SZ_RD: begin
                    n_sz = r_rdata;
                end
                D_T_RD: begin
                    n_t = r_rdata;
                end
                D_CUR_SPLIT: begin
                    // tail of the block becomes the new block
                    n_cur = r_cur + AW'(2) + rest[AW-1:0];
                end
                D_PREV_STEP: begin
                    n_prev = r_cur;
                    n_cnt  = r_cnt + CntW'(1);
                end
                D_ROVER: begin
                    n_rover = r_prev;
                end
                D_CNT_INC: begin
                    n_cnt = r_cnt + CntW'(1);
                end
                default: begin
                end
            endcase
        end

        if (fire && cw.done) begin
            n_out_valid = 1'b1;
            n_out       = result;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_CLR;
            r_cnt       <= '0;
            r_rover     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_cnt       <= n_cnt;
            r_rover     <= n_rover;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_bp    <= n_bp;
        r_units <= n_units;
        r_sz    <= n_sz;
        r_t     <= n_t;
        r_out   <= n_out;
    end

    `ASSERT_NEXT(a_done_loads_out, fire && cw.done, r_out_valid, "finished item not in output register")
    `ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && !o_in_stall, r_upc != U_IDLE, "accepted item not started")
    `ASSERT_NEXT(a_rover_stable, !(fire && cw.dop == D_ROVER), $stable(r_rover), "rover moved outside a finishing step")
    `ASSERT_HOLDS(a_walk_bound, r_cnt <= CntW'(MemWords + 1), "walk counter past its bound")

endmodule

/* tb/sv/tb_next_fit_free_list_allocator.sv */
// self-checking testbench for the next-fit free-list allocator
`timescale 1ns / 1ps

module tb_next_fit_free_list_allocator;
    import nffla_pkg::*;

    localparam int unsigned HeapWords = MemWords;
    localparam int HoldCycles = 400;
    localparam int LiveCap = 24;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } t_idle;

    typedef struct {
        int unsigned addr;
        int unsigned units;
    } t_live;

    class heap_scoreboard;
        logic [15:0] heap_img [HeapWords];
        int unsigned walk_start;
        t_out        expected_q [$];
        int          errors;
        int          n_grant;
        int          n_oom;
        int          n_free;
        int          n_seen;

        function new();
            foreach (heap_img[i]) heap_img[i] = '0;
            // one free block over the whole heap, linked to itself
            heap_img[1] = 16'(HeapWords - 2);
            walk_start = 0;
            errors = 0;
            n_grant = 0;
            n_oom = 0;
            n_free = 0;
            n_seen = 0;
        endfunction

        function int unsigned peek(int unsigned a);
            return heap_img[a % HeapWords];
        endfunction

        function void poke(int unsigned a, int unsigned v);
            heap_img[a % HeapWords] = v[15:0];
        endfunction

        function int unsigned link_of(int unsigned a);
            return peek(a) % HeapWords;
        endfunction

        function bit carve(int unsigned units, output int unsigned addr);
            int unsigned prev;
            int unsigned cur;
            int unsigned sz;
            int unsigned rest;
            addr = 0;
            prev = walk_start;
            cur = link_of(prev);
            for (int unsigned n = 0; n <= HeapWords; n++) begin
                sz = peek(cur + 1);
                if (sz >= units) begin
                    if (sz - units < 2) begin
                        // the list may never go empty
                        if (link_of(cur) == cur) return 1'b0;
                        poke(prev, peek(cur));
                    end else begin
                        rest = sz - units - 2;
                        poke(cur + 1, rest);
                        cur = (cur + 2 + rest) % HeapWords;
                        poke(cur + 1, units);
                    end
                    walk_start = prev;
                    addr = cur + 2;
                    return 1'b1;
                end
                if (cur == walk_start) return 1'b0;
                prev = cur;
                cur = link_of(cur);
            end
            return 1'b0;
        endfunction

        function void give_back(int unsigned data_addr);
            int unsigned bp;
            int unsigned p;
            int unsigned nx;
            bp = (data_addr + HeapWords - 2) % HeapWords;
            p = walk_start;
            for (int unsigned n = 0; n < HeapWords; n++) begin
                nx = link_of(p);
                if (bp > p && bp < nx) break;
                // wrap point of the circular list
                if (p >= nx && (bp > p || bp < nx)) break;
                p = nx;
            end
            nx = link_of(p);
            // sums are not wrapped, so nothing joins across the top
            if (bp + 2 + peek(bp + 1) == nx) begin
                poke(bp + 1, peek(bp + 1) + 2 + peek(nx + 1));
                poke(bp, peek(nx));
            end else begin
                poke(bp, nx);
            end
            if (p + 2 + peek(p + 1) == bp) begin
                poke(p + 1, peek(p + 1) + 2 + peek(bp + 1));
                poke(p, peek(bp));
            end else begin
                poke(p, bp);
            end
            walk_start = p;
        endfunction

        function t_out note_request(t_in req);
            t_out        exp;
            int unsigned addr;
            exp = '0;
            if (req.kind == KIND_ALLOC) begin
                if (carve(req.units, addr)) begin
                    exp.granted_address = addr[11:0];
                    exp.ok = 1'b1;
                    n_grant++;
                end else begin
                    n_oom++;
                end
            end else begin
                give_back(req.block_address);
                exp.ok = 1'b1;
                n_free++;
            end
            expected_q = {expected_q, exp};
            return exp;
        endfunction

        function void check_result(t_out got);
            t_out exp;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: granted_address %0d ok %0b",
                       got.granted_address, got.ok);
                errors++;
                return;
            end
            exp = expected_q[0];
            expected_q.delete(0);
            n_seen++;
            if (got.granted_address !== exp.granted_address) begin
                $error("granted_address: expected %0d, actual %0d",
                       exp.granted_address, got.granted_address);
                errors++;
            end
            if (got.ok !== exp.ok) begin
                $error("ok: expected %0b, actual %0b", exp.ok, got.ok);
                errors++;
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_in   i_in = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out;

    t_idle idle_mode = IDLE_NONE;
    logic  hold_token = 1'b0;
    logic  hold_seen = 1'b0;
    int    hold_left = 0;

    heap_scoreboard sb;
    t_live          live_q [$];
    int unsigned    freed_q [$];
    int unsigned    last_units = 0;

    next_fit_free_list_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (idle_mode)
                IDLE_RECV: i_out_stall <= ($urandom_range(99) < 86);
                IDLE_BOTH: i_out_stall <= ($urandom_range(99) < 36);
                default:   i_out_stall <= 1'b0;
            endcase
        end
    end

    // valid stays high on return, so back-to-back items need no extra edge
    task automatic offer(input t_in item, output t_out exp);
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SEND) begin
            while ($urandom_range(99) < 86) gap++;
        end else if (idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < 36) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (o_in_stall);
        exp = sb.note_request(item);
    endtask

    task automatic request_alloc(input int unsigned units);
        t_in   item;
        t_out  exp;
        t_live blk;
        item.kind = KIND_ALLOC;
        item.units = units[11:0];
        item.block_address = 12'($urandom());
        offer(item, exp);
        if (exp.ok) begin
            blk.addr = exp.granted_address;
            blk.units = units;
            live_q = {live_q, blk};
        end
    endtask

    task automatic request_free(input int unsigned addr);
        t_in  item;
        t_out exp;
        item.kind = KIND_FREE;
        item.units = 12'($urandom());
        item.block_address = addr[11:0];
        offer(item, exp);
    endtask

    task automatic free_live(input int idx);
        t_live blk;
        blk = live_q[idx];
        live_q.delete(idx);
        last_units = blk.units;
        freed_q = {freed_q, blk.addr};
        request_free(blk.addr);
    endtask

    task automatic random_step();
        int unsigned pick;
        if (live_q.size() == 0 || (live_q.size() < LiveCap && $urandom_range(99) < 55)) begin
            pick = $urandom_range(99);
            // refit right after a free lands on exact and near fits
            if (pick < 12) begin
                request_alloc(last_units > 0 ? last_units - $urandom_range(0, 1) : 0);
            end else if (pick < 25) begin
                request_alloc($urandom_range(0, 3));
            end else if (pick < 70) begin
                request_alloc($urandom_range(4, 64));
            end else if (pick < 92) begin
                request_alloc($urandom_range(65, 400));
            end else begin
                request_alloc($urandom_range(0, 4094));
            end
        end else begin
            free_live($urandom_range(0, live_q.size() - 1));
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.expected_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_idle mode, input int count);
        i_in_valid <= 1'b0;
        idle_mode <= mode;
        @(posedge i_clk);
        repeat (count) random_step();
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        request_alloc(0);       // tail at the very top, data address wraps to 0
        request_alloc(4094);
        request_alloc(4093);
        request_alloc(4092);    // sole block would leave whole
        request_alloc(4091);
        request_alloc(10);
        request_alloc(20);
        free_live(1);
        free_live(0);           // address 0 maps to the top header, no join across the top
        free_live(0);           // joins with both neighbors, heap whole again
        request_alloc(4094);
        request_alloc(4092);    // front block keeps zero words
        request_alloc(0);
        request_alloc(1);
        free_live(0);
        request_alloc(100);
        request_alloc(100);
        free_live(0);
        request_alloc(99);      // near fit takes the block whole
        free_live(1);
        request_alloc(100);     // exact fit
        while (live_q.size() != 0) free_live(0);

        run_phase(IDLE_NONE, 400);
        // output held off while input keeps coming
        hold_token <= ~hold_token;
        repeat (8) random_step();
        drain();
        run_phase(IDLE_SEND, 400);
        drain();
        run_phase(IDLE_RECV, 400);
        run_phase(IDLE_BOTH, 400);
        drain();

        // broken sequences last: they leave the heap meaningless
        request_free(1);
        request_free(4095);
        request_free(2);
        repeat (20) begin
            case ($urandom_range(2))
                0: request_free(freed_q[$urandom_range(0, freed_q.size() - 1)]);
                1: request_free($urandom_range(0, 4095));
                default: request_alloc($urandom_range(0, 4094));
            endcase
        end
        drain();
        repeat (40) @(posedge i_clk);

        $display("%0d grants, %0d out of memory, %0d frees; %0d results checked",
                 sb.n_grant, sb.n_oom, sb.n_free, sb.n_seen);
        $display("idle on neither, sender, receiver and both sides; long output hold; bad frees");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(100_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
